FILE: hdl/rhsl_pkg.sv
`timescale 1ns / 1ps
// rhsl_pkg: shared constants and types for the RGB to HSL converter.
// No dependencies.
package rhsl_pkg;

  localparam int CHANNEL_BITS_DEF = 12;

  // Hue is carried in sixteenths of a degree.
  localparam int HUE_BITS   = 13;
  localparam int HUE_Q_BITS = 10;  // one sixty-degree sector, 0..960
  localparam logic [HUE_BITS-1:0] HUE_TURN  = 13'd5760;
  localparam logic [HUE_BITS-1:0] HUE_GREEN = 13'd1920;
  localparam logic [HUE_BITS-1:0] HUE_BLUE  = 13'd3840;

  // Which channel is largest; red wins ties, then green.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

FILE: hdl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// rgb_to_hsl_converter: pipelined RGB to HSL colour conversion.
// Depends on rhsl_pkg (constants, sector type).

// Takes one pixel per clock while pixel_stall is low and returns one HSL
// result per pixel, in order. NQ = max(CHANNEL_BITS, 10). The pipeline is an
// input register, a max/min stage, a stage that forms the dividends and
// divisors, NQ restoring-division stages (one quotient bit per stage,
// saturation and hue side by side) and an output register. Sustained rate is
// one pixel per clock while hsl_stall is low; stall on the output side only
// holds stages that are full, so bubbles are squeezed out.
module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS = rhsl_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [CHANNEL_BITS-1:0]       red,
  input  logic [CHANNEL_BITS-1:0]       green,
  input  logic [CHANNEL_BITS-1:0]       blue,
  output logic                          hsl_valid,
  input  logic                          hsl_stall,
  output logic [rhsl_pkg::HUE_BITS-1:0] hue,
  output logic [CHANNEL_BITS-1:0]       saturation,
  output logic [CHANNEL_BITS-1:0]       lightness
);
  import rhsl_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int NQ = (CB > HUE_Q_BITS) ? CB : HUE_Q_BITS;
  localparam int W  = CB + NQ;
  localparam int NS = NQ + 4;
  localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};

  typedef struct packed {
    sector_t       sector;
    logic          neg;
    logic          gray;
    logic [CB-1:0] light;
  } meta_t;

  // ---------------- valid / advance ----------------
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  // A stage may load when it or any stage after it has a free slot, or when hsl_stall is low.
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !(&vld[NS-1:k]) || !hsl_stall;
  end

  assign pixel_stall = !adv[0];
  assign hsl_valid   = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (adv & {vld[NS-2:0], pixel_valid}) | (~adv & vld);
    end
  end

  // ---------------- stage A: input register ----------------
  logic [CB-1:0] ra, ga, ba;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ra <= red;
      ga <= green;
      ba <= blue;
    end
  end

  // ---------------- stage B: max, min, span ----------------
  sector_t       sec_c;
  logic [CB-1:0] mx_c, mn_c, op_p, op_m;
  logic          neg_c;
  logic [CB-1:0] mag_c;
  logic [CB-1:0] span_c;
  logic [CB:0]   sum_c;

  always_comb begin
    if (ra >= ga && ra >= ba) begin
      sec_c = SEC_RED;
      mx_c  = ra;
      op_p  = ga;
      op_m  = ba;
    end else if (ga >= ba) begin
      sec_c = SEC_GREEN;
      mx_c  = ga;
      op_p  = ba;
      op_m  = ra;
    end else begin
      sec_c = SEC_BLUE;
      mx_c  = ba;
      op_p  = ra;
      op_m  = ga;
    end
    mn_c = ra;
    if (ga < mn_c) mn_c = ga;
    if (ba < mn_c) mn_c = ba;
    neg_c  = op_p < op_m;
    mag_c  = neg_c ? (op_m - op_p) : (op_p - op_m);
    span_c = mx_c - mn_c;
    sum_c  = {1'b0, mx_c} + {1'b0, mn_c};
  end

  logic [CB-1:0] span_b, mag_b;
  logic [CB:0]   sum_b;
  meta_t         meta_b;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      span_b        <= span_c;
      mag_b         <= mag_c;
      sum_b         <= sum_c;
      meta_b.sector <= sec_c;
      meta_b.neg    <= neg_c;
      meta_b.gray   <= (span_c == '0);
      meta_b.light  <= sum_c[CB:1];
    end
  end

  // ---------------- stage C: dividends and divisors ----------------
  logic [CB:0]   den_wide;
  logic [CB-1:0] den_c;
  logic [W-1:0]  num_s_c, num_h_c;

  always_comb begin
    // Divisor never exceeds full scale on either branch.
    den_wide = (sum_b < FULL) ? sum_b : ((FULL << 1) - sum_b);
    den_c    = den_wide[CB-1:0];
    // span * full and |diff| * 960, as shift-and-subtract.
    num_s_c  = (W'(span_b) << CB) - W'(span_b);
    num_h_c  = (W'(mag_b) << 10) - (W'(mag_b) << 6);
  end

  // ---------------- restoring division stages ----------------
  logic [W-1:0]  rem_s [0:NQ];
  logic [W-1:0]  rem_h [0:NQ];
  logic [CB-1:0] den_s [0:NQ];
  logic [CB-1:0] den_h [0:NQ];
  logic [NQ-1:0] q_s   [0:NQ];
  logic [NQ-1:0] q_h   [0:NQ];
  meta_t         md    [0:NQ];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      rem_s[0] <= num_s_c;
      rem_h[0] <= num_h_c;
      den_s[0] <= den_c;
      den_h[0] <= span_b;
      q_s[0]   <= '0;
      q_h[0]   <= '0;
      md[0]    <= meta_b;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    localparam int SH = NQ - 1 - j;
    logic [W-1:0] sub_s, sub_h;
    logic         ge_s, ge_h;

    assign sub_s = W'(den_s[j]) << SH;
    assign sub_h = W'(den_h[j]) << SH;
    assign ge_s  = rem_s[j] >= sub_s;
    assign ge_h  = rem_h[j] >= sub_h;

    always_ff @(posedge clk) begin
      if (adv[j+3]) begin
        rem_s[j+1] <= ge_s ? (rem_s[j] - sub_s) : rem_s[j];
        rem_h[j+1] <= ge_h ? (rem_h[j] - sub_h) : rem_h[j];
        q_s[j+1]   <= q_s[j] | (ge_s ? (NQ'(1) << SH) : '0);
        q_h[j+1]   <= q_h[j] | (ge_h ? (NQ'(1) << SH) : '0);
        den_s[j+1] <= den_s[j];
        den_h[j+1] <= den_h[j];
        md[j+1]    <= md[j];
      end
    end
  end

  // ---------------- output stage ----------------
  logic [HUE_BITS-1:0] qx, hue_next;
  logic [CB-1:0]       sat_next;
  meta_t               mf;

  always_comb begin
    mf = md[NQ];
    qx = HUE_BITS'(q_h[NQ][HUE_Q_BITS-1:0]);
    case (mf.sector)
      SEC_RED:   hue_next = (mf.neg && qx != '0) ? (HUE_TURN - qx) : qx;
      SEC_GREEN: hue_next = mf.neg ? (HUE_GREEN - qx) : (HUE_GREEN + qx);
      SEC_BLUE:  hue_next = mf.neg ? (HUE_BLUE - qx) : (HUE_BLUE + qx);
      default:   hue_next = '0;
    endcase
    sat_next = q_s[NQ][CB-1:0];
    // Gray: no meaningful quotient, force hue and saturation to zero.
    if (mf.gray) begin
      hue_next = '0;
      sat_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      hue        <= hue_next;
      saturation <= sat_next;
      lightness  <= mf.light;
    end
  end

endmodule
